// File: hw/rtl/lgge_pkg.sv
// Shared definitions for the life grid generation engine.
// Operation codes, rule counts, neighborhood window type, default grid size.
// No dependencies.
package lgge_pkg;

  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_GRID_COLS = 64;

  localparam logic [1:0] FUNC_WRITE   = 2'd0;
  localparam logic [1:0] FUNC_ADVANCE = 2'd1;
  localparam logic [1:0] FUNC_READ    = 2'd2;

  // B3/S23
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

  // 3x3 neighborhood, bit 1 of each row is the center column
  typedef struct packed {
    logic [2:0] above;
    logic [2:0] cur;
    logic [2:0] below;
  } lgge_window_t;

endpackage

// File: hw/rtl/lgge_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lgge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/lgge_cell_rule.sv
// Shared neighbor count and B3/S23 decision for one cell per cycle.
// Depends on lgge_pkg.
module lgge_cell_rule import lgge_pkg::*; (
  input  lgge_window_t win,
  output logic         alive
);

  logic [3:0] n;

  always_comb begin
    n = 4'(win.above[0]) + 4'(win.above[1]) + 4'(win.above[2])
      + 4'(win.cur[0]) + 4'(win.cur[2])
      + 4'(win.below[0]) + 4'(win.below[1]) + 4'(win.below[2]);
    alive = (n == BIRTH_COUNT) || ((n == KEEP_COUNT) && win.cur[1]);
  end

endmodule

// File: hw/rtl/life_grid_generation_engine_core.sv
// Top level of the life grid generation engine: sequencer, line buffers, outputs.
// Depends on lgge_pkg, lgge_ram, lgge_cell_rule.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_ready   | in_func, in_row, in_col, in_value
//  out      | out_valid / out_ready | out_read_value, out_generation_count
//
// Cell write and read pass through S_CELL to S_DONE; an unused code goes straight to S_DONE.
// Advance passes S_A_TOP and S_A_CUR, then S_A_BEL, S_A_SWP and S_A_WB for each row: one shared
// rule unit visits one interior cell per cycle as the three row buffers rotate.
// After reset a clearing pass writes GRID_ROWS zero rows before in_ready rises.
// in_ready is high only when idle; a result waits in the output register.
module life_grid_generation_engine_core import lgge_pkg::*; #(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [4:0]  in_row,
  input  logic [5:0]  in_col,
  input  logic        in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_read_value,
  output logic [15:0] out_generation_count
);

  localparam int AW = $clog2(GRID_ROWS);
  localparam int KW = $clog2(GRID_COLS);

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CELL  = 9'b000000100,
    S_A_TOP = 9'b000001000,
    S_A_CUR = 9'b000010000,
    S_A_BEL = 9'b000100000,
    S_A_SWP = 9'b001000000,
    S_A_WB  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [AW-1:0]         row_r, row_nxt;
  logic [KW-1:0]         k_r, k_nxt;
  logic [GRID_COLS-1:0]  above_r, above_nxt;
  logic [GRID_COLS-1:0]  cur_r, cur_nxt;
  logic [GRID_COLS-1:0]  below_r, below_nxt;
  logic [GRID_COLS-1:0]  new_r, new_nxt;
  logic [1:0]            op_func_r, op_func_nxt;
  logic [AW-1:0]         op_row_r, op_row_nxt;
  logic [KW-1:0]         op_col_r, op_col_nxt;
  logic                  op_val_r, op_val_nxt;
  logic                  op_inside_r, op_inside_nxt;
  logic                  res_rv_r, res_rv_nxt;
  logic [15:0]           gen_r, gen_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_rv_r, out_rv_nxt;
  logic [15:0]           out_gen_r, out_gen_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [GRID_COLS-1:0]  ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [GRID_COLS-1:0]  ram_rdata;

  logic [8:0]            in_row_ext;
  logic [8:0]            in_col_ext;
  logic                  in_inside;
  logic [AW:0]           row_ext;
  logic [AW:0]           row_p1_w;
  logic [AW:0]           row_p2_w;
  logic [GRID_COLS-1:0]  wr_row;
  logic [GRID_COLS-1:0]  new_tmp;
  lgge_window_t          win;
  logic                  cell_alive;

  lgge_ram #(
    .WIDTH (GRID_COLS),
    .DEPTH (GRID_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign win.above = above_r[2:0];
  assign win.cur   = cur_r[2:0];
  assign win.below = below_r[2:0];

  lgge_cell_rule u_rule (
    .win   (win),
    .alive (cell_alive)
  );

  assign in_row_ext = 9'(in_row);
  assign in_col_ext = 9'(in_col);
  assign in_inside  = (in_row_ext < 9'(GRID_ROWS)) && (in_col_ext < 9'(GRID_COLS));
  assign row_ext    = (AW+1)'(row_r);
  assign row_p1_w   = row_ext + (AW+1)'(1);
  assign row_p2_w   = row_ext + (AW+1)'(2);

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    k_nxt         = k_r;
    above_nxt     = above_r;
    cur_nxt       = cur_r;
    below_nxt     = below_r;
    new_nxt       = new_r;
    op_func_nxt   = op_func_r;
    op_row_nxt    = op_row_r;
    op_col_nxt    = op_col_r;
    op_val_nxt    = op_val_r;
    op_inside_nxt = op_inside_r;
    res_rv_nxt    = res_rv_r;
    gen_nxt       = gen_r;
    out_valid_nxt = out_valid_r;
    out_rv_nxt    = out_rv_r;
    out_gen_nxt   = out_gen_r;
    ram_we        = 1'b0;
    ram_waddr     = row_r;
    ram_wdata     = '0;
    ram_raddr     = row_r;
    wr_row        = ram_rdata;
    new_tmp       = new_r;
    in_ready      = (state_r == S_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = row_r;
        ram_wdata = '0;
        if (row_r == AW'(GRID_ROWS - 1)) begin
          row_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          row_nxt = row_p1_w[AW-1:0];
        end
      end
      S_IDLE: begin
        ram_raddr = in_row_ext[AW-1:0];
        if (in_valid) begin
          op_func_nxt   = in_func;
          op_row_nxt    = in_row_ext[AW-1:0];
          op_col_nxt    = in_col_ext[KW-1:0];
          op_val_nxt    = in_value;
          op_inside_nxt = in_inside;
          priority if (in_func == FUNC_ADVANCE) begin
            ram_raddr = '0;
            state_nxt = S_A_TOP;
          end else if (in_func == FUNC_WRITE || in_func == FUNC_READ) begin
            state_nxt = S_CELL;
          end else begin
            res_rv_nxt = 1'b0;
            state_nxt  = S_DONE;
          end
        end
      end
      S_CELL: begin
        // row data of the addressed row arrives here; modify and write back
        if (op_func_r == FUNC_WRITE) begin
          wr_row[op_col_r] = op_val_r;
          ram_we     = op_inside_r;
          ram_waddr  = op_row_r;
          ram_wdata  = wr_row;
          res_rv_nxt = 1'b0;
        end else begin
          res_rv_nxt = op_inside_r & ram_rdata[op_col_r];
        end
        state_nxt = S_DONE;
      end
      S_A_TOP: begin
        above_nxt = ram_rdata;
        ram_raddr = AW'(1);
        row_nxt   = AW'(1);
        state_nxt = S_A_CUR;
      end
      S_A_CUR: begin
        cur_nxt   = ram_rdata;
        ram_raddr = row_p1_w[AW-1:0];
        state_nxt = S_A_BEL;
      end
      S_A_BEL: begin
        below_nxt = ram_rdata;
        new_nxt   = cur_r;
        k_nxt     = '0;
        state_nxt = S_A_SWP;
      end
      S_A_SWP: begin
        // step k sees columns k..k+2 at taps 0..2; full turn realigns buffers
        if (k_r <= KW'(GRID_COLS - 3)) begin
          new_tmp[1] = cell_alive;
        end
        new_nxt   = {new_tmp[0], new_tmp[GRID_COLS-1:1]};
        above_nxt = {above_r[0], above_r[GRID_COLS-1:1]};
        cur_nxt   = {cur_r[0], cur_r[GRID_COLS-1:1]};
        below_nxt = {below_r[0], below_r[GRID_COLS-1:1]};
        k_nxt     = k_r + KW'(1);
        if (k_r == KW'(GRID_COLS - 1)) begin
          state_nxt = S_A_WB;
        end
      end
      S_A_WB: begin
        ram_we    = 1'b1;
        ram_waddr = row_r;
        ram_wdata = new_r;
        above_nxt = cur_r;
        cur_nxt   = below_r;
        if (row_r == AW'(GRID_ROWS - 2)) begin
          gen_nxt    = gen_r + 16'd1;
          res_rv_nxt = 1'b0;
          state_nxt  = S_DONE;
        end else begin
          row_nxt   = row_p1_w[AW-1:0];
          ram_raddr = row_p2_w[AW-1:0];
          state_nxt = S_A_BEL;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rv_nxt    = res_rv_r;
          out_gen_nxt   = gen_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      row_r       <= '0;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      gen_r       <= gen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    above_r     <= above_nxt;
    cur_r       <= cur_nxt;
    below_r     <= below_nxt;
    new_r       <= new_nxt;
    op_func_r   <= op_func_nxt;
    op_row_r    <= op_row_nxt;
    op_col_r    <= op_col_nxt;
    op_val_r    <= op_val_nxt;
    op_inside_r <= op_inside_nxt;
    res_rv_r    <= res_rv_nxt;
    out_rv_r    <= out_rv_nxt;
    out_gen_r   <= out_gen_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_read_value       = out_rv_r;
  assign out_generation_count = out_gen_r;

`ifndef ASSERT_OFF
  // an accepted advance keeps the input closed for the sweep
  a_adv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_func == FUNC_ADVANCE) |=> !in_ready)
    else $error("input reopened right after an advance transfer");

  // generation counter only steps by one
  a_gen_step: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_r == $past(gen_r)) || (gen_r == 16'($past(gen_r) + 16'd1)))
    else $error("generation counter jumped");

  // grid is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we)
    else $error("grid write while idle");
`endif

endmodule

// File: dv/life_grid_generation_engine_core_test.sv
// Self-checking testbench for life_grid_generation_engine_core.
// Tracks the grid and generation count in its own B3/S23 model and checks each result.
// Depends on lgge_pkg and the core RTL only.
module life_grid_generation_engine_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lgge_pkg::*;

  localparam int LIFE_ROWS = DEF_GRID_ROWS;
  localparam int LIFE_COLS = DEF_GRID_COLS;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int LONG_HOLD = 400;

  typedef struct {
    logic        read_value;
    logic [15:0] generation_count;
  } cell_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [4:0]  in_row;
  logic [5:0]  in_col;
  logic        in_value;
  logic        out_valid;
  logic        out_ready;
  logic        out_read_value;
  logic [15:0] out_generation_count;

  // model of the grid and the generation counter
  bit [LIFE_COLS-1:0] life_rows [LIFE_ROWS];
  logic [15:0]        gen_count;

  cell_report_t pending_reports[$];

  int  items_sent;
  int  reports_checked;
  int  mismatch_count;
  int  cycle_count;
  bit  tx_gaps_on;
  bit  rx_stalls_on;
  int  rx_hold_cycles;

  life_grid_generation_engine_core #(
    .GRID_ROWS(LIFE_ROWS),
    .GRID_COLS(LIFE_COLS)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_func              (in_func),
    .in_row               (in_row),
    .in_col               (in_col),
    .in_value             (in_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_read_value       (out_read_value),
    .out_generation_count (out_generation_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_reports.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // One generation: interior cells from a snapshot of the old grid, borders untouched.
  function automatic void step_generation();
    bit [LIFE_COLS-1:0] prev [LIFE_ROWS];
    int live;
    prev = life_rows;
    for (int r = 1; r < LIFE_ROWS - 1; r++) begin
      for (int c = 1; c < LIFE_COLS - 1; c++) begin
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) live += prev[r + dr][c + dc];
          end
        end
        if (live == BIRTH_COUNT) life_rows[r][c] = 1'b1;
        else if (live != KEEP_COUNT) life_rows[r][c] = 1'b0;
      end
    end
    gen_count++;
  endfunction

  function automatic cell_report_t apply_cell_op(logic [1:0] func, int row, int col,
                                                 logic value);
    cell_report_t rep;
    rep.read_value = 1'b0;
    case (func)
      FUNC_WRITE:   life_rows[row][col] = value;
      FUNC_ADVANCE: step_generation();
      FUNC_READ:    rep.read_value = life_rows[row][col];
      default:      ;
    endcase
    rep.generation_count = gen_count;
    return rep;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Drives one operation and returns at the edge where it transfers.
  task automatic send_op(input logic [1:0] func, input int row, input int col,
                         input logic value);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 12) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= func;
    in_row   <= 5'(row);
    in_col   <= 6'(col);
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(apply_cell_op(func, row, col, value));
    items_sent++;
  endtask

  // Sender goes quiet until every pending result has come back.
  task automatic wait_for_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic check_report();
    cell_report_t want;
    if (pending_reports.size() == 0) begin
      note_failure($sformatf("result with nothing pending: read %0b gen %0d",
                             out_read_value, out_generation_count));
      return;
    end
    want = pending_reports.pop_front();
    reports_checked++;
    if (out_read_value !== want.read_value ||
        out_generation_count !== want.generation_count)
      note_failure($sformatf("result %0d: read exp %0b got %0b, gen exp %0d got %0d",
                             reports_checked, want.read_value, out_read_value,
                             want.generation_count, out_generation_count));
  endtask

  // Result side: random stall per transfer, or one long hold when requested.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_stalls_on ? $urandom_range(0, 12) : 0;
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_report();
    end
  end

  task automatic test_directed_cases();
    send_op(FUNC_READ, 0, 0, 1'b0);
    send_op(FUNC_READ, LIFE_ROWS - 1, LIFE_COLS - 1, 1'b1);
    send_op(FUNC_UNUSED, LIFE_ROWS - 1, LIFE_COLS - 1, 1'b1);
    // corners
    send_op(FUNC_WRITE, 0, 0, 1'b1);
    send_op(FUNC_WRITE, LIFE_ROWS - 1, LIFE_COLS - 1, 1'b1);
    send_op(FUNC_WRITE, 0, LIFE_COLS - 1, 1'b1);
    send_op(FUNC_WRITE, LIFE_ROWS - 1, 0, 1'b1);
    send_op(FUNC_READ, 0, 0, 1'b0);
    send_op(FUNC_READ, LIFE_ROWS - 1, LIFE_COLS - 1, 1'b0);
    send_op(FUNC_WRITE, LIFE_ROWS - 1, LIFE_COLS - 1, 1'b0);
    send_op(FUNC_READ, LIFE_ROWS - 1, LIFE_COLS - 1, 1'b0);
    // three live cells on the top border: births below, border itself frozen
    send_op(FUNC_WRITE, 0, 10, 1'b1);
    send_op(FUNC_WRITE, 0, 11, 1'b1);
    send_op(FUNC_WRITE, 0, 12, 1'b1);
    // horizontal blinker
    send_op(FUNC_WRITE, 10, 20, 1'b1);
    send_op(FUNC_WRITE, 10, 21, 1'b1);
    send_op(FUNC_WRITE, 10, 22, 1'b1);
    send_op(FUNC_ADVANCE, LIFE_ROWS - 1, LIFE_COLS - 1, 1'b1);
    send_op(FUNC_READ, 1, 11, 1'b0);
    send_op(FUNC_READ, 0, 11, 1'b0);
    send_op(FUNC_READ, 9, 21, 1'b0);
    send_op(FUNC_READ, 10, 20, 1'b0);
    send_op(FUNC_ADVANCE, 0, 0, 1'b0);
    send_op(FUNC_READ, 10, 20, 1'b1);
    send_op(FUNC_UNUSED, 0, 0, 1'b0);
  endtask

  // Seed a small patch, step it a few generations, then read around it.
  task automatic test_pattern_sequences(input int item_budget);
    int first;
    int top;
    int left;
    first = items_sent;
    while (items_sent - first < item_budget) begin
      top  = $urandom_range(0, LIFE_ROWS - 4);
      left = $urandom_range(0, LIFE_COLS - 4);
      tx_gaps_on   = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 9))
        send_op(FUNC_WRITE, top + $urandom_range(0, 3), left + $urandom_range(0, 3),
                $urandom_range(0, 5) != 0);
      // broken sequence now and then: stray write or unused code mid-pattern
      if ($urandom_range(0, 4) == 0)
        send_op($urandom_range(0, 1) ? FUNC_UNUSED : FUNC_WRITE,
                $urandom_range(0, LIFE_ROWS - 1), $urandom_range(0, LIFE_COLS - 1),
                1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 3))
        send_op(FUNC_ADVANCE, $urandom_range(0, LIFE_ROWS - 1),
                $urandom_range(0, LIFE_COLS - 1), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(3, 8))
        send_op(FUNC_READ, (top + LIFE_ROWS - 1 + $urandom_range(0, 5)) % LIFE_ROWS,
                (left + LIFE_COLS - 1 + $urandom_range(0, 5)) % LIFE_COLS,
                1'($urandom_range(0, 1)));
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_random_ops(input int count);
    logic [1:0] func;
    repeat (count) begin
      func = 2'($urandom_range(0, 3));
      // keep slow advances to a minority
      if (func == FUNC_ADVANCE && $urandom_range(0, 3) != 0) func = FUNC_READ;
      send_op(func, $urandom_range(0, LIFE_ROWS - 1), $urandom_range(0, LIFE_COLS - 1),
              1'($urandom_range(0, 1)));
    end
  endtask

  // Output held off while input keeps offering: core fills and stalls in_ready.
  task automatic test_output_backpressure();
    rx_hold_cycles = LONG_HOLD;
    tx_gaps_on = 1'b0;
    repeat (10)
      send_op($urandom_range(0, 1) ? FUNC_READ : FUNC_WRITE,
              $urandom_range(0, LIFE_ROWS - 1), $urandom_range(0, LIFE_COLS - 1),
              1'($urandom_range(0, 1)));
    tx_gaps_on = 1'b1;
    wait_for_reports();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FUNC_WRITE;
    in_row          = '0;
    in_col          = '0;
    in_value        = 1'b0;
    gen_count       = '0;
    items_sent      = 0;
    reports_checked = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    tx_gaps_on      = 1'b1;
    rx_stalls_on    = 1'b1;
    rx_hold_cycles  = 0;
    foreach (life_rows[r]) life_rows[r] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_pattern_sequences(195);
    test_output_backpressure();
    test_random_ops(50);

    wait_for_reports();
    repeat (20) @(posedge clk);
    $display("%0d operations transferred, %0d results checked, %0d generations stepped;",
             items_sent, reports_checked, gen_count);
    $display("covered corner/border cells, blinker and border births, unused code, long stall");
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
